### hw/rtl/txcon_pkg.sv
// Shared types and constants for the text console writer.
package txcon_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_TOTAL = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);
  localparam int CUR_W      = $clog2(CELL_TOTAL + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int IDX_W      = 11;
  localparam int CHAR_W     = 8;
  localparam int MODE_W     = 3;
  localparam int CELL_W     = 16;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 3'd0,
    MODE_NL    = 3'd1,
    MODE_BS    = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } txcon_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_cell;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_attr;
    logic              scrolled;
  } txcon_out_t;

  typedef enum logic [8:0] {
    ST_INIT   = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_EXEC   = 9'b000000100,
    ST_RD     = 9'b000001000,
    ST_SCR_RD = 9'b000010000,
    ST_SCR_WR = 9'b000100000,
    ST_FILL   = 9'b001000000,
    ST_CLR    = 9'b010000000,
    ST_DONE   = 9'b100000000
  } ctrl_state_e;

  typedef struct packed {
    logic init_wr;
    logic accept;
    logic op_put;
    logic op_nl;
    logic op_bs;
    logic op_clr;
    logic op_rd;
    logic rd_capture;
    logic scr_rd;
    logic scr_wr;
    logic fill_wr;
    logic clr_wr;
    logic load_out;
  } txcon_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              put_scroll;
    logic              nl_scroll;
    logic              cursor_zero;
    logic              idx_ok;
    logic              copy_last;
    logic              ptr_last;
    logic              out_free;
  } txcon_status_t;

endpackage

### hw/rtl/text_console_writer_top.sv
// Top level of the text console writer: sequencer plus cell datapath.
// Each word is accepted, executed and its result loaded into the output register; a read
//   adds a capture step, a scroll a cell-by-cell copy up one row and a blank fill of the last row.
// The sequencer handles one word at a time: a new word is accepted only once the last
//   word's result has been loaded into the output register.
// Reset: async active low; a clearing pass over all CELL_TOTAL cells (2000) blanks the memory,
//   with input stalled meanwhile; attribute resets to 0x07, cursor to cell 0.
module text_console_writer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  txcon_pkg::txcon_in_t         in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output txcon_pkg::txcon_out_t        out_data_o,
  input  logic                         cfg_we_i,
  input  logic [txcon_pkg::CHAR_W-1:0] cfg_wdata_i
);

  // Command and status bundles are the only link between sequencer and datapath.
  txcon_pkg::txcon_cmd_t    cmd;
  txcon_pkg::txcon_status_t status;

  // Sequencer: one state per memory sweep step; holds the input stall high
  // until the current word's result is handed to the output register.
  txcon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath: cell memory, cursor and column tracking, sweep pointer for
  // clear and scroll, and the output register that parts the two channels.
  txcon_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hw/rtl/txcon_ctrl.sv
// Sequencer for the text console: decodes each word and steps the datapath.
module txcon_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  txcon_pkg::txcon_status_t status_i,
  output txcon_pkg::txcon_cmd_t    cmd_o,
  output logic                     in_stall_o
);

  txcon_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= txcon_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != txcon_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      txcon_pkg::ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.ptr_last) state_d = txcon_pkg::ST_IDLE;
      end
      txcon_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = txcon_pkg::ST_EXEC;
        end
      end
      txcon_pkg::ST_EXEC: begin
        case (status_i.mode)
          txcon_pkg::MODE_PUT: begin
            cmd_o.op_put = 1'b1;
            state_d = status_i.put_scroll ? txcon_pkg::ST_SCR_RD : txcon_pkg::ST_DONE;
          end
          txcon_pkg::MODE_NL: begin
            cmd_o.op_nl = 1'b1;
            state_d = status_i.nl_scroll ? txcon_pkg::ST_SCR_RD : txcon_pkg::ST_DONE;
          end
          txcon_pkg::MODE_BS: begin
            // drop backspace at the home cell
            cmd_o.op_bs = !status_i.cursor_zero;
            state_d     = txcon_pkg::ST_DONE;
          end
          txcon_pkg::MODE_CLEAR: begin
            cmd_o.op_clr = 1'b1;
            state_d      = txcon_pkg::ST_CLR;
          end
          txcon_pkg::MODE_READ: begin
            cmd_o.op_rd = status_i.idx_ok;
            state_d = status_i.idx_ok ? txcon_pkg::ST_RD : txcon_pkg::ST_DONE;
          end
          default: begin
            state_d = txcon_pkg::ST_DONE;
          end
        endcase
      end
      txcon_pkg::ST_RD: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = txcon_pkg::ST_DONE;
      end
      txcon_pkg::ST_SCR_RD: begin
        cmd_o.scr_rd = 1'b1;
        state_d      = txcon_pkg::ST_SCR_WR;
      end
      txcon_pkg::ST_SCR_WR: begin
        cmd_o.scr_wr = 1'b1;
        state_d = status_i.copy_last ? txcon_pkg::ST_FILL : txcon_pkg::ST_SCR_RD;
      end
      txcon_pkg::ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.ptr_last) state_d = txcon_pkg::ST_DONE;
      end
      txcon_pkg::ST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.ptr_last) state_d = txcon_pkg::ST_DONE;
      end
      txcon_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = txcon_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = txcon_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/txcon_dp.sv
// Datapath for the text console: cell memory, cursor, sweep pointer, output register.
module txcon_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  txcon_pkg::txcon_cmd_t      cmd_i,
  output txcon_pkg::txcon_status_t   status_o,
  input  txcon_pkg::txcon_in_t       in_data_i,
  input  logic                       cfg_we_i,
  input  logic [txcon_pkg::CHAR_W-1:0] cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output txcon_pkg::txcon_out_t      out_data_o
);

  localparam int AW = txcon_pkg::ADDR_W;
  localparam int CW = txcon_pkg::CUR_W;
  localparam int LW = txcon_pkg::COL_W;

  logic [txcon_pkg::CELL_W-1:0] mem_q [txcon_pkg::CELL_TOTAL];
  logic [txcon_pkg::CELL_W-1:0] rdata_q;

  txcon_pkg::txcon_in_t        item_q;
  txcon_pkg::txcon_out_t       out_q;
  logic [txcon_pkg::CHAR_W-1:0] attr_q, res_char_q, res_attr_q;
  logic [CW-1:0]               cursor_q, cursor_d;
  logic [LW-1:0]               col_q, col_d;
  logic [AW-1:0]               ptr_q, ptr_d;
  logic                        scrolled_q, scrolled_d;
  logic                        out_valid_q;

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [txcon_pkg::CELL_W-1:0] mem_wdata, blank;
  logic [CW-1:0]               cur_dec, nl_base;
  logic                        ptr_step;

  assign blank    = {attr_q, txcon_pkg::BLANK_CHAR};
  assign cur_dec  = cursor_q - CW'(1);
  assign nl_base  = cursor_q - CW'(col_q);
  assign ptr_step = cmd_i.init_wr | cmd_i.scr_wr | cmd_i.fill_wr | cmd_i.clr_wr;

  assign status_o.mode        = item_q.mode;
  assign status_o.put_scroll  = (cursor_q == CW'(txcon_pkg::CELL_TOTAL - 1));
  assign status_o.nl_scroll   =
    (nl_base == CW'(txcon_pkg::CELL_TOTAL - txcon_pkg::COLUMNS));
  assign status_o.cursor_zero = (cursor_q == '0);
  assign status_o.idx_ok      = (item_q.cell_index < txcon_pkg::CELL_TOTAL);
  assign status_o.copy_last   =
    (ptr_q == AW'(txcon_pkg::CELL_TOTAL - txcon_pkg::COLUMNS - 1));
  assign status_o.ptr_last    = (ptr_q == AW'(txcon_pkg::CELL_TOTAL - 1));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // single write port, single read port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = ptr_q + AW'(txcon_pkg::COLUMNS);
    if (cmd_i.init_wr) begin
      mem_we    = 1'b1;
      mem_wdata = {txcon_pkg::RESET_ATTR, txcon_pkg::BLANK_CHAR};
    end else if (cmd_i.op_put) begin
      mem_we    = 1'b1;
      mem_waddr = cursor_q[AW-1:0];
      mem_wdata = {attr_q, item_q.char_code};
    end else if (cmd_i.op_bs) begin
      mem_we    = 1'b1;
      mem_waddr = cur_dec[AW-1:0];
    end else if (cmd_i.scr_wr) begin
      mem_we    = 1'b1;
      mem_wdata = rdata_q;
    end else if (cmd_i.fill_wr || cmd_i.clr_wr) begin
      mem_we    = 1'b1;
    end
    if (cmd_i.op_rd) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(item_q.cell_index);
    end else if (cmd_i.scr_rd) begin
      mem_re    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    cursor_d   = cursor_q;
    col_d      = col_q;
    scrolled_d = scrolled_q;
    ptr_d      = ptr_q;
    if (ptr_step) begin
      ptr_d = status_o.ptr_last ? '0 : ptr_q + AW'(1);
    end
    if (cmd_i.accept) begin
      scrolled_d = 1'b0;
    end
    if (cmd_i.op_put) begin
      if (status_o.put_scroll) begin
        cursor_d   = CW'(txcon_pkg::CELL_TOTAL - txcon_pkg::COLUMNS);
        col_d      = '0;
        scrolled_d = 1'b1;
      end else begin
        cursor_d = cursor_q + CW'(1);
        col_d    = (col_q == LW'(txcon_pkg::COLUMNS - 1)) ? '0 : col_q + LW'(1);
      end
    end
    if (cmd_i.op_nl) begin
      col_d = '0;
      if (status_o.nl_scroll) begin
        cursor_d   = CW'(txcon_pkg::CELL_TOTAL - txcon_pkg::COLUMNS);
        scrolled_d = 1'b1;
      end else begin
        cursor_d = nl_base + CW'(txcon_pkg::COLUMNS);
      end
    end
    if (cmd_i.op_bs) begin
      cursor_d = cur_dec;
      col_d    = (col_q == '0) ? LW'(txcon_pkg::COLUMNS - 1) : col_q - LW'(1);
    end
    if (cmd_i.op_clr) begin
      cursor_d = '0;
      col_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      scrolled_q  <= 1'b0;
      attr_q      <= txcon_pkg::RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      ptr_q       <= ptr_d;
      scrolled_q  <= scrolled_d;
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      out_valid_q <= cmd_i.load_out | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q     <= in_data_i;
      res_char_q <= '0;
      res_attr_q <= '0;
    end
    if (cmd_i.rd_capture) begin
      res_char_q <= rdata_q[txcon_pkg::CHAR_W-1:0];
      res_attr_q <= rdata_q[txcon_pkg::CELL_W-1:txcon_pkg::CHAR_W];
    end
    if (cmd_i.load_out) begin
      out_q.cursor_cell <= txcon_pkg::IDX_W'(cursor_q);
      out_q.read_char   <= res_char_q;
      out_q.read_attr   <= res_attr_q;
      out_q.scrolled    <= scrolled_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/txcon_checker.sv
// Port-level checker for the text console writer, bound to the top level.
module txcon_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input txcon_pkg::txcon_in_t         in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input txcon_pkg::txcon_out_t        out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input word dropped or changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word dropped or changed");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cursor_cell < txcon_pkg::CELL_TOTAL))
    else $error("cursor outside the screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.scrolled |->
      (out_data_o.cursor_cell ==
       txcon_pkg::IDX_W'(txcon_pkg::CELL_TOTAL - txcon_pkg::COLUMNS)))
    else $error("scroll did not leave cursor at start of last row");

  a_read_no_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.read_char != '0) || (out_data_o.read_attr != '0)) |->
      !out_data_o.scrolled)
    else $error("read data and scroll reported together");

endmodule

bind text_console_writer_top txcon_checker u_txcon_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
